// ----- hdl/ifr_pkg.sv -----
// Shared types and constants for the image flip and rotate engine.
// No dependencies; every other file of the block but ifr_ram imports this package.
package ifr_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PIX_W  = 32;
	localparam int unsigned DIM_W  = 7;
	localparam int unsigned BPP_W  = 3;
	// Pixel counts and products of two dimensions both fit in 14 bits.
	localparam int unsigned CNT_W  = 14;
	localparam int unsigned PROD_W = 14;
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	localparam logic [DIM_W-1:0] RST_WIDTH  = 7'd64;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 7'd64;
	localparam logic [BPP_W-1:0] RST_BPP    = 3'd4;
	localparam logic             RST_MODE   = 1'b0;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	localparam logic MODE_FLIP   = 1'b0;
	localparam logic MODE_ROTATE = 1'b1;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BPP    = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FULL   = 2'd1,
		ST_STILL_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_ADDR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic              action;
		logic [CHAN_W-1:0] in_chan0;
		logic [CHAN_W-1:0] in_chan1;
		logic [CHAN_W-1:0] in_chan2;
		logic [CHAN_W-1:0] in_chan3;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_chan0;
		logic [CHAN_W-1:0] out_chan1;
		logic [CHAN_W-1:0] out_chan2;
		logic [CHAN_W-1:0] out_chan3;
		logic              last_pixel;
		logic [1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [BPP_W-1:0] bytes_per_pixel;
		logic             transform_mode;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic addr;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fetch_go;
		logic out_free;
	} dp_sts_t;

	function automatic logic [PIX_W-1:0] byte_mask(input logic [BPP_W-1:0] bpp);
		logic [PIX_W-1:0] m;
		begin
			unique case (bpp)
				3'd1:    m = 32'h0000_00FF;
				3'd2:    m = 32'h0000_FFFF;
				3'd3:    m = 32'h00FF_FFFF;
				default: m = 32'hFFFF_FFFF;
			endcase
			return m;
		end
	endfunction

endpackage

// ----- hdl/ifr_item_if.sv -----
// Request channel of the image flip and rotate engine.
// Depends on ifr_pkg for the request payload type.
interface ifr_item_if;
	import ifr_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ifr_result_if.sv -----
// Result channel of the image flip and rotate engine.
// Depends on ifr_pkg for the result payload type.
interface ifr_result_if;
	import ifr_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ifr_regs.sv -----
// APB configuration registers: width, height, pixel size and transform mode.
// Depends on ifr_pkg.
module ifr_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ifr_pkg::APB_AW-1:0] paddr,
	input  logic [ifr_pkg::APB_DW-1:0] pwdata,
	output logic [ifr_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output ifr_pkg::cfg_t             cfg
);
	import ifr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_WIDTH;
			cfg_q.image_height    <= RST_HEIGHT;
			cfg_q.bytes_per_pixel <= RST_BPP;
			cfg_q.transform_mode  <= RST_MODE;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:  cfg_q.image_width     <= pwdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.image_height    <= pwdata[DIM_W-1:0];
				REG_BPP:    cfg_q.bytes_per_pixel <= pwdata[BPP_W-1:0];
				REG_MODE:   cfg_q.transform_mode  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
			REG_BPP:    prdata = APB_DW'(cfg_q.bytes_per_pixel);
			REG_MODE:   prdata = APB_DW'(cfg_q.transform_mode);
		endcase
	end

endmodule

// ----- hdl/ifr_ctrl.sv -----
// Controller state machine: sequences accept, execute, address and respond.
// Depends on ifr_pkg for the state, command and status types.
module ifr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ifr_pkg::dp_sts_t   sts,
	output ifr_pkg::ctrl_cmd_t cmd
);
	import ifr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = sts.fetch_go ? S_ADDR : S_RESP;
			end
			S_ADDR: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = (state_q == S_IDLE);
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.addr    = (state_q == S_ADDR);
		cmd.emit    = (state_q == S_RESP) && sts.out_free;
	end

endmodule

// ----- hdl/ifr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ifr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/ifr_datapath.sv -----
// Datapath: load counter, output scan position, address arithmetic, frame
// store and result register. Depends on ifr_pkg, ifr_result_if and ifr_ram.
module ifr_datapath #(
	parameter int unsigned MAX_DIM    = 64,
	parameter int unsigned MAX_PIXELS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ifr_pkg::ctrl_cmd_t cmd,
	output ifr_pkg::dp_sts_t   sts,
	input  ifr_pkg::cfg_t      cfg,
	input  ifr_pkg::in_item_t  in_item,
	ifr_result_if.source       results
);
	import ifr_pkg::*;

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned XW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam int unsigned DIM_CAP = (MAX_DIM < 127) ? MAX_DIM : 127;
	localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);
	localparam logic [XW-1:0] PIX_LIMIT = XW'(MAX_PIXELS);

	// Control state.
	logic [CNT_W-1:0] load_cnt_q;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic             full_q;
	logic             out_valid_q;

	// Item and result payload.
	in_item_t         item_q;
	logic [PROD_W-1:0] total_q;
	logic [1:0]       res_status_q;
	logic             res_last_q;
	logic             use_ram_q;
	out_item_t        out_q;
	logic [PROD_W-1:0] prod_s1;
	logic [DIM_W-1:0] sc_s1;
	logic             inr_s1;

	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic [BPP_W-1:0] bpp_c;
	logic [PIX_W-1:0] mask;
	logic [DIM_W-1:0] ow;
	logic [DIM_W-1:0] oh;
	logic [DIM_W:0]   col_inc;
	logic [DIM_W:0]   row_inc;
	logic             col_end;
	logic             row_end;
	logic [DIM_W:0]   sc_x;
	logic [DIM_W:0]   sr_x;
	logic             in_range;
	logic [CNT_W:0]   lc_nxt;
	logic [XW-1:0]    lc_x;
	logic [XW-1:0]    addr_x;
	logic             is_load;
	logic             wr_en;
	logic [PIX_W-1:0] wr_data;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] pix;

	// Register values outside the legal range saturate.
	always_comb begin
		if (cfg.image_width == '0)            w_c = DIM_W'(1);
		else if (cfg.image_width > DIM_CAP_V) w_c = DIM_CAP_V;
		else                                  w_c = cfg.image_width;
		if (cfg.image_height == '0)            h_c = DIM_W'(1);
		else if (cfg.image_height > DIM_CAP_V) h_c = DIM_CAP_V;
		else                                   h_c = cfg.image_height;
		if (cfg.bytes_per_pixel == '0)        bpp_c = BPP_W'(1);
		else if (cfg.bytes_per_pixel > 3'd4)  bpp_c = BPP_W'(4);
		else                                  bpp_c = cfg.bytes_per_pixel;
	end

	assign mask = byte_mask(bpp_c);

	always_ff @(posedge clk) begin
		total_q <= PROD_W'(w_c) * PROD_W'(h_c);
	end

	// Output scan position and the source coordinate it maps to. The extra
	// top bit of each coordinate catches a subtraction that went negative.
	always_comb begin
		ow      = (cfg.transform_mode == MODE_ROTATE) ? h_c : w_c;
		oh      = (cfg.transform_mode == MODE_ROTATE) ? w_c : h_c;
		col_inc = {1'b0, col_q} + (DIM_W+1)'(1);
		row_inc = {1'b0, row_q} + (DIM_W+1)'(1);
		col_end = (col_inc >= {1'b0, ow});
		row_end = (row_inc >= {1'b0, oh});
		if (cfg.transform_mode == MODE_ROTATE) begin
			sc_x = {1'b0, w_c} - (DIM_W+1)'(1) - {1'b0, row_q};
			sr_x = {1'b0, col_q};
		end else begin
			sc_x = {1'b0, col_q};
			sr_x = {1'b0, h_c} - (DIM_W+1)'(1) - {1'b0, row_q};
		end
		in_range = !sc_x[DIM_W] && (sc_x[DIM_W-1:0] < w_c)
			&& !sr_x[DIM_W] && (sr_x[DIM_W-1:0] < h_c);
	end

	assign is_load = (item_q.action == ACT_LOAD);
	assign lc_nxt  = {1'b0, load_cnt_q} + (CNT_W+1)'(1);
	assign lc_x    = XW'(load_cnt_q);
	assign wr_en   = cmd.exec && is_load && !full_q && (lc_x < PIX_LIMIT);
	assign wr_data = {item_q.in_chan3, item_q.in_chan2, item_q.in_chan1, item_q.in_chan0}
		& mask;
	assign addr_x  = XW'(prod_s1) + XW'(sc_s1);

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			full_q     <= 1'b0;
		end else if (cmd.exec) begin
			if (is_load) begin
				if (!full_q) begin
					load_cnt_q <= lc_nxt[CNT_W-1:0];
					if (lc_nxt >= {1'b0, total_q}) full_q <= 1'b1;
				end
			end else if (full_q) begin
				if (col_end && row_end) begin
					full_q     <= 1'b0;
					load_cnt_q <= '0;
					row_q      <= '0;
					col_q      <= '0;
				end else if (col_end) begin
					col_q <= '0;
					row_q <= row_inc[DIM_W-1:0];
				end else begin
					col_q <= col_inc[DIM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			use_ram_q  <= 1'b0;
			res_last_q <= 1'b0;
			prod_s1    <= PROD_W'(sr_x[DIM_W-1:0]) * PROD_W'(w_c);
			sc_s1      <= sc_x[DIM_W-1:0];
			inr_s1     <= in_range;
			if (is_load) begin
				res_status_q <= full_q ? ST_STILL_FULL : ST_OK;
			end else if (!full_q) begin
				res_status_q <= ST_NOT_FULL;
			end else begin
				res_status_q <= ST_OK;
				res_last_q   <= col_end && row_end;
			end
		end else if (cmd.addr) begin
			use_ram_q <= inr_s1 && (addr_x < PIX_LIMIT);
		end
	end

	ifr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_PIXELS)
	) u_frame (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (lc_x[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (cmd.addr),
		.rd_addr (addr_x[AW-1:0]),
		.rd_data (rd_data)
	);

	assign pix = use_ram_q ? (rd_data & mask) : '0;

	// The result register lets a new request in while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_chan0  <= pix[7:0];
			out_q.out_chan1  <= pix[15:8];
			out_q.out_chan2  <= pix[23:16];
			out_q.out_chan3  <= pix[31:24];
			out_q.last_pixel <= res_last_q;
			out_q.status     <= res_status_q;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;
	assign sts.out_free    = !out_valid_q || results.ready;
	assign sts.fetch_go    = (item_q.action == ACT_FETCH) && full_q;

endmodule

// ----- hdl/image_flip_and_rotate_core.sv -----
// Frame transform engine. Load requests fill the frame store in raster order;
// once width * height pixels are in, fetch requests return the image either
// flipped vertically or rotated 90 degrees counter-clockwise, one pixel per
// request, and the final pixel carries last_pixel. A load steps through accept,
// execute and respond; a fetch on a full frame store adds the address step and a
// registered read. Respond waits for a free result register; the controller handles
// one request at a time. Results are held in an output register, so a new
// request is accepted while the previous result waits. Misordered requests
// return a nonzero status and change nothing.
// Depends on ifr_pkg, the channel interfaces, ifr_regs, ifr_ctrl and ifr_datapath.
module image_flip_and_rotate_core #(
	parameter int unsigned MAX_DIM    = 64,
	parameter int unsigned MAX_PIXELS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ifr_item_if.sink                   items,
	ifr_result_if.source               results,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ifr_pkg::APB_AW-1:0] paddr,
	input  logic [ifr_pkg::APB_DW-1:0] pwdata,
	output logic [ifr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import ifr_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;
	logic      in_ready;

	ifr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ifr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign items.ready = in_ready;

	ifr_datapath #(
		.MAX_DIM    (MAX_DIM),
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg),
		.in_item (items.payload),
		.results (results)
	);

endmodule

// ----- hdl/ifr_checker.sv -----
// Port-level checks for the image flip and rotate engine, bound to the top.
// Depends on ifr_pkg and image_flip_and_rotate_core.
module ifr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ifr_pkg::out_item_t  out_payload
);
	import ifr_pkg::*;

	// One request at a time: after an accept the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while the previous one was in progress");

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.last_pixel |-> out_payload.status == ST_OK)
		else $error("last pixel flagged on a rejected request");

	a_reject_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.status != ST_OK |->
			out_payload.out_chan0 == '0 && out_payload.out_chan1 == '0
			&& out_payload.out_chan2 == '0 && out_payload.out_chan3 == '0)
		else $error("rejected request returned pixel data");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled result changed");

endmodule

bind image_flip_and_rotate_core ifr_checker u_ifr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_payload (results.payload)
);
